[hw/rtl/dmbt_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dmbt_pkg
// Shared constants, types and small lookup functions for the broadcast
// time-field decoder (MJD plus BCD time of day to calendar and unix time).
// ----------------------------------------------------------------------------
package dmbt_pkg;

    // number of register stages in the datapath
    localparam int unsigned STAGES = 8;

    // MJD of 1970-01-01
    localparam logic [15:0] EPOCH_MJD = 16'd40587;

    // year estimate: floor((20*mjd - 301564) / 7305)
    localparam logic [20:0] YEAR_NUM_BIAS   = 21'd301564;
    localparam logic [12:0] YEAR_DIVISOR    = 13'd7305;
    // ceil(2^24 / 7305), quotient estimate is exact or one too high
    localparam logic [11:0] YEAR_RECIP      = 12'd2297;

    // days in four julian years, A = floor(Y*1461/4)
    localparam logic [17:0] DAYS_PER_4Y     = 18'd1461;

    // march-based day offset
    localparam logic [16:0] MJD_MARCH_BASE  = 17'd14956;

    localparam logic [10:0] BASE_YEAR       = 11'd1900;
    localparam logic [16:0] SECS_PER_DAY    = 17'd86400;

    // month index range and wrap codes for january and february
    localparam logic [4:0] MONTH_IDX_MAX    = 5'd16;
    localparam logic [4:0] MONTH_IDX_JAN    = 5'd14;
    localparam logic [4:0] MONTH_IDX_FEB    = 5'd15;
    localparam logic [4:0] MONTH_IDX_BIAS   = 5'd1;
    localparam logic [4:0] MONTHS_PER_YEAR  = 5'd12;

    // per-stage pipeline control
    typedef struct packed {
        logic [STAGES-1:0] load;
        logic [STAGES-1:0] valid;
    } dmbt_flow_t;

    // bcd byte: high nibble times ten plus low nibble, digits a..f not rejected
    function automatic logic [7:0] bcd_byte(input logic [7:0] b);
        return ({4'd0, b[7:4]} * 8'd10) + {4'd0, b[3:0]};
    endfunction

    // floor(m * 30.6001) for month index m
    function automatic logic [8:0] month_floor(input logic [4:0] m);
        logic [8:0] f;
        case (m)
            5'd1:    f = 9'd30;
            5'd2:    f = 9'd61;
            5'd3:    f = 9'd91;
            5'd4:    f = 9'd122;
            5'd5:    f = 9'd153;
            5'd6:    f = 9'd183;
            5'd7:    f = 9'd214;
            5'd8:    f = 9'd244;
            5'd9:    f = 9'd275;
            5'd10:   f = 9'd306;
            5'd11:   f = 9'd336;
            5'd12:   f = 9'd367;
            5'd13:   f = 9'd397;
            5'd14:   f = 9'd428;
            5'd15:   f = 9'd459;
            5'd16:   f = 9'd489;
            default: f = 9'd0;
        endcase
        return f;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/dvb_mjd_bcd_time_decoder_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dvb_mjd_bcd_time_decoder_top
// Broadcast time-field decoder: MJD and BCD hh:mm:ss in, calendar date,
// decoded time of day, unix seconds and a short time hash out.
// ----------------------------------------------------------------------------
// usage
//   input request: day_number, bcd_clock, taken when item_valid is high and
//   item_stall is low. result request: all output fields, taken when
//   result_valid is high and result_stall is low. one result per request.
//   each request passes the eight register stages of the date path (year
//   quotient by reciprocal multiply and correction, four-year day count,
//   month search, day and year fixup) before result_valid rises; one
//   request per cycle is sustained while result_stall is low.
//   every stage has its own valid bit and loads whenever it is empty or
//   its content moves on, so while result_stall is high the pipe keeps
//   accepting until all stages are full, then item_stall rises. nothing
//   is dropped or repeated under stall.
//   reset clears all valid bits; no clearing pass, requests are taken in
//   the first cycle after reset.
//   dates before 1970-01-01 are raised to that day and epoch_clamped is set.
// ----------------------------------------------------------------------------
module dvb_mjd_bcd_time_decoder_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire logic [15:0] day_number,
    input  wire logic [23:0] bcd_clock,
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic [31:0]      unix_seconds,
    output logic [10:0]      year_full,
    output logic [3:0]       month_of_year,
    output logic [4:0]       day_of_month,
    output logic [7:0]       hour_value,
    output logic [7:0]       minute_value,
    output logic [7:0]       second_value,
    output logic [15:0]      time_hash,
    output logic             epoch_clamped
);

    dmbt_pkg::dmbt_flow_t flow;

    // pipeline control
    dmbt_flow u_flow (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_stall (result_stall),
        .flow         (flow)
    );

    // ---------------- stage 1: clamp, year numerator, bcd decode
    logic [15:0] mjd1_next,   mjd1_reg;
    logic [19:0] num1_next,   num1_reg;
    logic [14:0] dd1_next,    dd1_reg;
    logic [7:0]  hh1_next,    hh1_reg;
    logic [7:0]  mm1_next,    mm1_reg;
    logic [7:0]  ss1_next,    ss1_reg;
    logic        clamp1_next, clamp1_reg;
    logic [20:0] mjd_x20;
    logic [20:0] num_full;
    logic [15:0] dd_full;

    always_comb
    begin
        clamp1_next = day_number < dmbt_pkg::EPOCH_MJD;
        mjd1_next   = clamp1_next ? dmbt_pkg::EPOCH_MJD : day_number;
        mjd_x20     = {1'b0, mjd1_next, 4'b0} + {3'b0, mjd1_next, 2'b0};
        num_full    = mjd_x20 - dmbt_pkg::YEAR_NUM_BIAS;
        num1_next   = num_full[19:0];
        dd_full     = mjd1_next - dmbt_pkg::EPOCH_MJD;
        dd1_next    = dd_full[14:0];
        hh1_next    = dmbt_pkg::bcd_byte(bcd_clock[23:16]);
        mm1_next    = dmbt_pkg::bcd_byte(bcd_clock[15:8]);
        ss1_next    = dmbt_pkg::bcd_byte(bcd_clock[7:0]);
    end

    always_ff @(posedge clk)
    begin
        if (flow.load[0])
        begin
            mjd1_reg   <= mjd1_next;
            num1_reg   <= num1_next;
            dd1_reg    <= dd1_next;
            hh1_reg    <= hh1_next;
            mm1_reg    <= mm1_next;
            ss1_reg    <= ss1_next;
            clamp1_reg <= clamp1_next;
        end
    end

    // ---------------- stage 2: reciprocal product, day seconds, time of day
    logic [31:0] prod2_next,  prod2_reg;
    logic [31:0] dsec2_next,  dsec2_reg;
    logic [19:0] tod2_next,   tod2_reg;
    logic [13:0] hm2_next,    hm2_reg;
    logic [15:0] mjd2_reg;
    logic [19:0] num2_reg;
    logic [7:0]  hh2_reg, mm2_reg, ss2_reg;
    logic        clamp2_reg;

    always_comb
    begin
        prod2_next = {12'b0, num1_reg} * {20'b0, dmbt_pkg::YEAR_RECIP};
        dsec2_next = {17'b0, dd1_reg} * {15'b0, dmbt_pkg::SECS_PER_DAY};
        tod2_next  = ({12'b0, hh1_reg} * 20'd3600) + ({12'b0, mm1_reg} * 20'd60)
                   + {12'b0, ss1_reg};
        hm2_next   = ({6'b0, hh1_reg} * 14'd60) + {6'b0, mm1_reg};
    end

    always_ff @(posedge clk)
    begin
        if (flow.load[1])
        begin
            prod2_reg  <= prod2_next;
            dsec2_reg  <= dsec2_next;
            tod2_reg   <= tod2_next;
            hm2_reg    <= hm2_next;
            mjd2_reg   <= mjd1_reg;
            num2_reg   <= num1_reg;
            hh2_reg    <= hh1_reg;
            mm2_reg    <= mm1_reg;
            ss2_reg    <= ss1_reg;
            clamp2_reg <= clamp1_reg;
        end
    end

    // ---------------- stage 3: quotient estimate, back product, unix seconds
    logic [7:0]  q3_next,    q3_reg;
    logic [20:0] back3_next, back3_reg;
    logic [31:0] secs3_next, secs3_reg;
    logic [15:0] mjd3_reg;
    logic [19:0] num3_reg;
    logic [13:0] hm3_reg;
    logic [7:0]  hh3_reg, mm3_reg, ss3_reg;
    logic        clamp3_reg;

    always_comb
    begin
        q3_next    = prod2_reg[31:24];
        back3_next = {13'b0, q3_next} * {8'b0, dmbt_pkg::YEAR_DIVISOR};
        secs3_next = dsec2_reg + {12'b0, tod2_reg};
    end

    always_ff @(posedge clk)
    begin
        if (flow.load[2])
        begin
            q3_reg     <= q3_next;
            back3_reg  <= back3_next;
            secs3_reg  <= secs3_next;
            mjd3_reg   <= mjd2_reg;
            num3_reg   <= num2_reg;
            hm3_reg    <= hm2_reg;
            hh3_reg    <= hh2_reg;
            mm3_reg    <= mm2_reg;
            ss3_reg    <= ss2_reg;
            clamp3_reg <= clamp2_reg;
        end
    end

    // ---------------- stage 4: quotient correction gives year offset
    logic [7:0]  y4_next, y4_reg;
    logic [15:0] mjd4_reg;
    logic [31:0] secs4_reg;
    logic [13:0] hm4_reg;
    logic [7:0]  hh4_reg, mm4_reg, ss4_reg;
    logic        clamp4_reg;

    always_comb
    begin
        y4_next = (back3_reg > {1'b0, num3_reg}) ? (q3_reg - 8'd1) : q3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (flow.load[3])
        begin
            y4_reg     <= y4_next;
            mjd4_reg   <= mjd3_reg;
            secs4_reg  <= secs3_reg;
            hm4_reg    <= hm3_reg;
            hh4_reg    <= hh3_reg;
            mm4_reg    <= mm3_reg;
            ss4_reg    <= ss3_reg;
            clamp4_reg <= clamp3_reg;
        end
    end

    // ---------------- stage 5: days in whole years
    logic [15:0] a5_next, a5_reg;
    logic [17:0] ydays;
    logic [7:0]  y5_reg;
    logic [15:0] mjd5_reg;
    logic [31:0] secs5_reg;
    logic [13:0] hm5_reg;
    logic [7:0]  hh5_reg, mm5_reg, ss5_reg;
    logic        clamp5_reg;

    always_comb
    begin
        ydays   = {10'b0, y4_reg} * dmbt_pkg::DAYS_PER_4Y;
        a5_next = ydays[17:2];
    end

    always_ff @(posedge clk)
    begin
        if (flow.load[4])
        begin
            a5_reg     <= a5_next;
            y5_reg     <= y4_reg;
            mjd5_reg   <= mjd4_reg;
            secs5_reg  <= secs4_reg;
            hm5_reg    <= hm4_reg;
            hh5_reg    <= hh4_reg;
            mm5_reg    <= mm4_reg;
            ss5_reg    <= ss4_reg;
            clamp5_reg <= clamp4_reg;
        end
    end

    // ---------------- stage 6: day within march-based year
    logic [8:0]  e6_next, e6_reg;
    logic [16:0] e_full;
    logic [7:0]  y6_reg;
    logic [31:0] secs6_reg;
    logic [13:0] hm6_reg;
    logic [7:0]  hh6_reg, mm6_reg, ss6_reg;
    logic        clamp6_reg;

    always_comb
    begin
        e_full  = {1'b0, mjd5_reg} - dmbt_pkg::MJD_MARCH_BASE - {1'b0, a5_reg};
        e6_next = e_full[8:0];
    end

    always_ff @(posedge clk)
    begin
        if (flow.load[5])
        begin
            e6_reg     <= e6_next;
            y6_reg     <= y5_reg;
            secs6_reg  <= secs5_reg;
            hm6_reg    <= hm5_reg;
            hh6_reg    <= hh5_reg;
            mm6_reg    <= mm5_reg;
            ss6_reg    <= ss5_reg;
            clamp6_reg <= clamp5_reg;
        end
    end

    // ---------------- stage 7: month index by threshold count
    logic [4:0]  m7_next, m7_reg;
    logic [8:0]  e7_reg;
    logic [7:0]  y7_reg;
    logic [31:0] secs7_reg;
    logic [13:0] hm7_reg;
    logic [7:0]  hh7_reg, mm7_reg, ss7_reg;
    logic        clamp7_reg;

    always_comb
    begin
        m7_next = 5'd0;
        for (int j = 1; j <= int'(dmbt_pkg::MONTH_IDX_MAX); j++)
        begin
            if (e6_reg > dmbt_pkg::month_floor(5'(j)))
            begin
                m7_next = m7_next + 5'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (flow.load[6])
        begin
            m7_reg     <= m7_next;
            e7_reg     <= e6_reg;
            y7_reg     <= y6_reg;
            secs7_reg  <= secs6_reg;
            hm7_reg    <= hm6_reg;
            hh7_reg    <= hh6_reg;
            mm7_reg    <= mm6_reg;
            ss7_reg    <= ss6_reg;
            clamp7_reg <= clamp6_reg;
        end
    end

    // ---------------- stage 8: day, year and month fixup, hash
    logic [31:0] secs8_next,  secs8_reg;
    logic [10:0] year8_next,  year8_reg;
    logic [3:0]  month8_next, month8_reg;
    logic [4:0]  day8_next,   day8_reg;
    logic [15:0] hash8_next,  hash8_reg;
    logic [7:0]  hh8_reg, mm8_reg, ss8_reg;
    logic        clamp8_reg;
    logic [8:0]  d_full;
    logic        wrap;
    logic [4:0]  m_fix;

    always_comb
    begin
        d_full      = e7_reg - dmbt_pkg::month_floor(m7_reg);
        wrap        = (m7_reg == dmbt_pkg::MONTH_IDX_JAN) || (m7_reg == dmbt_pkg::MONTH_IDX_FEB);
        m_fix       = m7_reg - dmbt_pkg::MONTH_IDX_BIAS
                    - (wrap ? dmbt_pkg::MONTHS_PER_YEAR : 5'd0);
        day8_next   = d_full[4:0];
        month8_next = m_fix[3:0];
        year8_next  = dmbt_pkg::BASE_YEAR + {3'b0, y7_reg} + {10'b0, wrap};
        hash8_next  = {2'b0, hm7_reg} | {day8_next, 11'b0};
        secs8_next  = secs7_reg;
    end

    always_ff @(posedge clk)
    begin
        if (flow.load[7])
        begin
            secs8_reg  <= secs8_next;
            year8_reg  <= year8_next;
            month8_reg <= month8_next;
            day8_reg   <= day8_next;
            hash8_reg  <= hash8_next;
            hh8_reg    <= hh7_reg;
            mm8_reg    <= mm7_reg;
            ss8_reg    <= ss7_reg;
            clamp8_reg <= clamp7_reg;
        end
    end

    // result request
    assign result_valid  = flow.valid[dmbt_pkg::STAGES-1];
    assign unix_seconds  = secs8_reg;
    assign year_full     = year8_reg;
    assign month_of_year = month8_reg;
    assign day_of_month  = day8_reg;
    assign hour_value    = hh8_reg;
    assign minute_value  = mm8_reg;
    assign second_value  = ss8_reg;
    assign time_hash     = hash8_reg;
    assign epoch_clamped = clamp8_reg;

endmodule
`default_nettype wire

[hw/rtl/dmbt_flow.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dmbt_flow
// Valid bits and per-stage load enables for the datapath. A stage loads when
// it is empty or its content moves on, so bubbles collapse under a stall.
// ----------------------------------------------------------------------------
module dmbt_flow (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_stall,
    input  wire logic               result_stall,
    output dmbt_pkg::dmbt_flow_t    flow
);

    localparam int unsigned N = dmbt_pkg::STAGES;

    logic [N-1:0] valid_reg;
    logic [N-1:0] valid_next;
    logic [N:0]   ready;
    logic [N-1:0] up_valid;

    // ready ripples back from the result side
    always_comb
    begin
        ready[N] = !result_stall;
        for (int i = N - 1; i >= 0; i--)
        begin
            ready[i] = !valid_reg[i] || ready[i+1];
        end
        up_valid   = {valid_reg[N-2:0], item_valid};
        valid_next = valid_reg;
        for (int i = 0; i < N; i++)
        begin
            if (ready[i])
            begin
                valid_next[i] = up_valid[i];
            end
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign item_stall = !ready[0];
    assign flow.load  = ready[N-1:0] & up_valid;
    assign flow.valid = valid_reg;

endmodule
`default_nettype wire
